[rtl/dgus_pkg.sv]
// shared types and constants for the directed graph unreachable set core
`default_nettype none

package dgus_pkg;

  // fixed field widths
  localparam int unsigned VertexW = 7;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned RegW    = 32;
  localparam int unsigned AddrW   = 3;

  // command codes carried in tuser
  localparam logic [CmdW-1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [CmdW-1:0] CMD_QUERY    = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR    = 2'd2;

  // register index
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [VertexW-1:0] VertexCountReset = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_EXPAND,
    ST_COUNT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

[rtl/directed_graph_unreachable_set_core.sv]
// directed graph reachability core: adjacency memory, traversal and unreached-vertex report
//
//  channel   | direction | handshake               | payload
//  s_axis    | in        | tvalid/tready           | tuser cmd, tdata edges and start vertex
//  m_axis    | out       | tvalid/tready           | tdata count and vertex, tlast
//  apb       | in        | psel/penable/pwrite     | vertex_count at byte address 0
//
// add edge: read, modify, write of one adjacency row (ADD_RD, ADD_WR); clear, ignored edges and
// unused codes finish in the idle state.
// query: traversal (EXPAND), count pass over lim vertices (COUNT), then results (EMIT), which wait on output stalls,
// lim = min(vertex_count, rows); the traversal is bound by the single read port, one
// adjacency row per cycle.
// rows carry valid bits cleared at reset and by a clear item, so no clearing pass is needed.
// a stalled result waits in the output register; the input side opens again after the last
// result of a query has been loaded, whether or not it was taken.
`default_nettype none

module directed_graph_unreachable_set_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // stream in
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [23:0]                  s_axis_tdata,   // edge_from, edge_to, start_vertex, pad
  input  wire  [dgus_pkg::CmdW-1:0]    s_axis_tuser,   // cmd
  // stream out
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // unreached_count, unreached_vertex, pad
  output logic                         m_axis_tlast,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [dgus_pkg::AddrW-1:0]   paddr,
  input  wire  [dgus_pkg::RegW-1:0]    pwdata,
  output logic [dgus_pkg::RegW-1:0]    prdata,
  output logic                         pready
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned LW = (CW > dgus_pkg::VertexW) ? CW : dgus_pkg::VertexW;
  localparam logic [LW-1:0] MaxV = LW'(MAX_VERTICES);

  // ------------------------------------------------------------------ config
  logic [dgus_pkg::VertexW-1:0] vcount_q;
  logic                         cfg_wr;
  logic                         cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == dgus_pkg::REG_VERTEX_COUNT);
  assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;
  assign prdata  = cfg_hit ? dgus_pkg::RegW'(vcount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= dgus_pkg::VertexCountReset;
    end else if (cfg_wr) begin
      vcount_q <= pwdata[dgus_pkg::VertexW-1:0];
    end
  end

  logic [LW-1:0]           lim;
  logic [LW-1:0]           vc_ext;
  logic [MAX_VERTICES-1:0] vmask;

  assign vc_ext = LW'(vcount_q);
  assign lim    = (vc_ext > MaxV) ? MaxV : vc_ext;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      vmask[i] = (LW'(i) < lim);
    end
  end

  // ------------------------------------------------------------------ input fields
  logic [dgus_pkg::CmdW-1:0]    in_cmd;
  logic [LW-1:0]                in_from;
  logic [LW-1:0]                in_to;
  logic [LW-1:0]                in_start;
  logic                         in_acc;
  logic                         edge_ok;
  logic                         start_ok;

  assign in_cmd   = s_axis_tuser;
  assign in_from  = LW'(s_axis_tdata[6:0]);
  assign in_to    = LW'(s_axis_tdata[13:7]);
  assign in_start = LW'(s_axis_tdata[20:14]);
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign edge_ok  = (in_from != '0) && (in_from <= MaxV) && (in_to != '0) && (in_to <= MaxV);
  assign start_ok = (in_start != '0) && (in_start <= lim);

  // ------------------------------------------------------------------ adjacency memory
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [MAX_VERTICES-1:0] rd_q;
  logic                    rd_ok_q;
  logic                    mem_re;
  logic [VW-1:0]           mem_raddr;
  logic                    mem_we;
  logic [MAX_VERTICES-1:0] mem_wdata;
  logic                    clear_all;
  logic [VW-1:0]           edge_row_q, edge_row_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      adj_mem[edge_row_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= adj_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (mem_re) begin
        rd_ok_q <= row_vld_q[mem_raddr];
      end
      if (clear_all) begin
        row_vld_q <= '0;
      end else if (mem_we) begin
        row_vld_q[edge_row_q] <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ control
  dgus_pkg::state_e state_q, state_d;

  logic [VW-1:0]           edge_col_q, edge_col_d;
  logic [MAX_VERTICES-1:0] reached_q, reached_d;
  logic [MAX_VERTICES-1:0] expanded_q, expanded_d;
  logic                    pend_q, pend_d;
  logic [LW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           rem_q, rem_d;

  logic                           mv_q, mv_d;
  logic [dgus_pkg::VertexW-1:0]   mcount_q, mcount_d;
  logic [dgus_pkg::VertexW-1:0]   mvert_q, mvert_d;
  logic                           mlast_q, mlast_d;

  logic [MAX_VERTICES-1:0] rd_row;
  logic [MAX_VERTICES-1:0] cur_reached;
  logic [MAX_VERTICES-1:0] cand;
  logic [VW-1:0]           cand_idx;
  logic                    out_free;
  logic                    scan_end;
  logic                    cur_unreached;

  function automatic logic [VW-1:0] first_set(input logic [MAX_VERTICES-1:0] v);
    logic [VW-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) r = VW'(i);
    end
    return r;
  endfunction

  // merged row is forwarded into the candidate search of the same cycle
  assign rd_row        = rd_ok_q ? (rd_q & vmask) : '0;
  assign cur_reached   = reached_q | (pend_q ? rd_row : '0);
  assign cand          = cur_reached & ~expanded_q;
  assign cand_idx      = first_set(cand);
  assign out_free      = !mv_q || m_axis_tready;
  assign scan_end      = (idx_q == lim);
  assign cur_unreached = !reached_q[idx_q[VW-1:0]];

  assign s_axis_tready = (state_q == dgus_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    edge_row_d = edge_row_q;
    edge_col_d = edge_col_q;
    reached_d  = reached_q;
    expanded_d = expanded_q;
    pend_d     = 1'b0;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    mv_d       = mv_q && !m_axis_tready;
    mcount_d   = mcount_q;
    mvert_d    = mvert_q;
    mlast_d    = mlast_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    clear_all  = 1'b0;

    case (state_q)
      dgus_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            dgus_pkg::CMD_ADD_EDGE: begin
              if (edge_ok) begin
                edge_row_d = VW'(in_from - 1'b1);
                edge_col_d = VW'(in_to - 1'b1);
                state_d    = dgus_pkg::ST_ADD_RD;
              end
            end
            dgus_pkg::CMD_QUERY: begin
              reached_d  = '0;
              expanded_d = '0;
              // the start row is merged without marking the start as expanded
              if (start_ok) begin
                mem_re    = 1'b1;
                mem_raddr = VW'(in_start - 1'b1);
                pend_d    = 1'b1;
              end
              state_d = dgus_pkg::ST_EXPAND;
            end
            dgus_pkg::CMD_CLEAR: begin
              clear_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      dgus_pkg::ST_ADD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = edge_row_q;
        state_d   = dgus_pkg::ST_ADD_WR;
      end

      dgus_pkg::ST_ADD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (rd_ok_q ? rd_q : '0) | (MAX_VERTICES'(1) << edge_col_q);
        state_d   = dgus_pkg::ST_IDLE;
      end

      dgus_pkg::ST_EXPAND: begin
        reached_d = cur_reached;
        if (cand != '0) begin
          mem_re               = 1'b1;
          mem_raddr            = cand_idx;
          expanded_d           = expanded_q;
          expanded_d[cand_idx] = 1'b1;
          pend_d               = 1'b1;
        end else begin
          idx_d   = '0;
          cnt_d   = '0;
          state_d = dgus_pkg::ST_COUNT;
        end
      end

      dgus_pkg::ST_COUNT: begin
        if (scan_end) begin
          idx_d   = '0;
          rem_d   = cnt_q;
          state_d = dgus_pkg::ST_EMIT;
        end else begin
          cnt_d = cnt_q + CW'(cur_unreached);
          idx_d = idx_q + 1'b1;
        end
      end

      dgus_pkg::ST_EMIT: begin
        if (cnt_q == '0) begin
          if (out_free) begin
            mv_d     = 1'b1;
            mcount_d = '0;
            mvert_d  = '0;
            mlast_d  = 1'b1;
            state_d  = dgus_pkg::ST_IDLE;
          end
        end else if (cur_unreached) begin
          if (out_free) begin
            mv_d     = 1'b1;
            mcount_d = dgus_pkg::VertexW'(cnt_q);
            mvert_d  = dgus_pkg::VertexW'(idx_q + 1'b1);
            mlast_d  = (rem_q == CW'(1));
            rem_d    = rem_q - 1'b1;
            idx_d    = idx_q + 1'b1;
            if (rem_q == CW'(1)) begin
              state_d = dgus_pkg::ST_IDLE;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = dgus_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dgus_pkg::ST_IDLE;
      pend_q  <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_row_q <= edge_row_d;
    edge_col_q <= edge_col_d;
    reached_q  <= reached_d;
    expanded_q <= expanded_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    mcount_q   <= mcount_d;
    mvert_q    <= mvert_d;
    mlast_q    <= mlast_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {2'b00, mvert_q, mcount_q};
  assign m_axis_tlast  = mlast_q;

endmodule

`default_nettype wire

[rtl/dgus_checker.sv]
// port-level checks for the directed graph unreachable set core
`default_nettype none

module dgus_checker #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         s_axis_tvalid,
  input wire                         s_axis_tready,
  input wire [dgus_pkg::CmdW-1:0]    s_axis_tuser,
  input wire                         m_axis_tvalid,
  input wire                         m_axis_tready,
  input wire [15:0]                  m_axis_tdata,
  input wire                         m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a query item keeps the input closed for at least the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == dgus_pkg::CMD_QUERY
      |=> !s_axis_tready)
    else $error("input open right after a query item");

  // a clear leaves the input open in the next cycle
  a_clear_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == dgus_pkg::CMD_CLEAR |=> s_axis_tready)
    else $error("input closed after a clear item");

  // vertex 0 only appears in the single all-reached result
  a_zero_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (MAX_VERTICES < 127) && m_axis_tvalid && m_axis_tdata[13:7] == 7'd0 |->
      m_axis_tlast && m_axis_tdata[6:0] == 7'd0)
    else $error("vertex 0 reported outside the all-reached result");

endmodule

bind directed_graph_unreachable_set_core dgus_checker #(
  .MAX_VERTICES(MAX_VERTICES)
) u_dgus_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
